/* hw/rtl/scc_pkg.sv */
// shared types and constants for the strip cluster accumulator
package scc_pkg;

   localparam int NUM_STRIPS  = 768;
   localparam int MAX_CLUSTER = 64;

   localparam int STRIP_W  = 10;
   localparam int SIGNAL_W = 10;
   localparam int SIGMA_W  = 16;
   localparam int WEIGHT_W = 16;
   localparam int SUM_W    = 20;
   localparam int NOISE_W  = 24;
   localparam int COUNT_W  = 7;
   localparam int MEAN_W   = 18;
   localparam int LOW_W    = 11;

   localparam int MUL_A_W = 20;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = MUL_P_W + 1;
   localparam int DIV_STEPS = MEAN_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [WEIGHT_W-1:0] ONE_Q15   = 16'h8000;
   localparam logic [SUM_W-1:0]    SIG_MAX   = '1;
   localparam logic [NOISE_W-1:0]  NOISE_MAX = '1;
   localparam logic [MEAN_W-1:0]   MEAN_MAX  = '1;
   localparam logic [LOW_W-1:0]    LOW_EMPTY = LOW_W'(NUM_STRIPS + 1);
   localparam logic [COUNT_W-1:0]  COUNT_MAX = COUNT_W'(MAX_CLUSTER);

   typedef struct packed {
      logic                start_cluster;
      logic [STRIP_W-1:0]  strip_number;
      logic [SIGNAL_W-1:0] strip_signal;
      logic [SIGMA_W-1:0]  strip_sigma;
      logic [WEIGHT_W-1:0] share_weight;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0]    total_signal;
      logic [NOISE_W-1:0]  total_noise;
      logic [STRIP_W-1:0]  first_strip;
      logic [SIGNAL_W-1:0] first_signal;
      logic [SIGNAL_W-1:0] last_signal;
      logic [COUNT_W-1:0]  strip_count;
      logic [MEAN_W-1:0]   centroid;
      logic                zero_total;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [ACC_W-1:0]   dividend;
      logic [SUM_W-1:0]   divisor;
   } div_req_type;

endpackage

/* hw/rtl/scc_divider.sv */
// iterative restoring divider for the centroid, one quotient bit per cycle, clamped
module scc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  scc_pkg::div_req_type          div_req,
   output logic                          done,
   output logic [scc_pkg::MEAN_W-1:0]    quotient
);

   typedef enum logic [2:0] {
      DIV_IDLE  = 3'b001,
      DIV_CHECK = 3'b010,
      DIV_RUN   = 3'b100
   } div_state_type;

   localparam int HI_W = scc_pkg::ACC_W - scc_pkg::MEAN_W;

   div_state_type                   state_ff;
   logic                            done_ff;
   logic [scc_pkg::MEAN_W-1:0]      quot_ff;
   logic [HI_W-1:0]                 hi_ff;
   logic [scc_pkg::MEAN_W-1:0]      low_ff;
   logic [scc_pkg::SUM_W-1:0]       divisor_ff;
   logic [scc_pkg::SUM_W-1:0]       rem_ff;
   logic [scc_pkg::DIV_CNT_W-1:0]   count_ff;

   logic [scc_pkg::SUM_W:0]         trial;
   logic                            qbit;
   logic [scc_pkg::SUM_W:0]         trial_diff;

   always_comb begin
      trial      = {rem_ff, low_ff[scc_pkg::MEAN_W-1]};
      qbit       = trial >= {1'b0, divisor_ff};
      trial_diff = trial - {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            DIV_IDLE: begin
               if (div_req.start) begin
                  state_ff <= DIV_CHECK;
               end
            end
            DIV_CHECK: begin
               count_ff <= '0;
               if (hi_ff >= HI_W'(divisor_ff)) begin
                  done_ff  <= 1'b1;
                  state_ff <= DIV_IDLE;
               end else begin
                  state_ff <= DIV_RUN;
               end
            end
            DIV_RUN: begin
               count_ff <= count_ff + 1'b1;
               if (count_ff == scc_pkg::DIV_CNT_W'(scc_pkg::DIV_STEPS - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= DIV_IDLE;
               end
            end
            default: begin
               state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DIV_IDLE: begin
            if (div_req.start) begin
               hi_ff      <= div_req.dividend[scc_pkg::ACC_W-1:scc_pkg::MEAN_W];
               low_ff     <= div_req.dividend[scc_pkg::MEAN_W-1:0];
               divisor_ff <= div_req.divisor;
            end
         end
         DIV_CHECK: begin
            rem_ff <= hi_ff[scc_pkg::SUM_W-1:0];
            if (hi_ff >= HI_W'(divisor_ff)) begin
               quot_ff <= scc_pkg::MEAN_MAX;
            end
         end
         DIV_RUN: begin
            low_ff <= {low_ff[scc_pkg::MEAN_W-2:0], qbit};
            rem_ff <= qbit ? trial_diff[scc_pkg::SUM_W-1:0] : trial[scc_pkg::SUM_W-1:0];
            if (count_ff == scc_pkg::DIV_CNT_W'(scc_pkg::DIV_STEPS - 1)) begin
               quot_ff <= {low_ff[scc_pkg::MEAN_W-2:0], qbit};
            end
         end
         default: begin
         end
      endcase
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

/* hw/rtl/strip_cluster_accumulator.sv */
// strip cluster accumulator top level: sequencer, shared multiplier and cluster state
//
// usage:
//   req_ channel takes one strip word (strip number, adc signal, sigma,
//   sharing weight, start flag). start_cluster clears the cluster first.
//   rsp_ channel returns one word per strip with the cluster after the update:
//   sums, lowest strip and its signal, right edge signal, count, centroid.
// sequence:
//   an accepted strip makes four passes through the shared 20x18 multiplier
//   (signal, noise, mean, position), then the divider start, the overflow
//   check, the 18 quotient bits in the restoring divider, the done handoff and
//   the output load that raises rsp_valid. a new strip is taken only after that
//   load. a zero signal total skips the divider; a clamped centroid ends after
//   the overflow check.
//   req_ready is high only while the sequencer is idle.
// reset:
//   synchronous active high reset empties the cluster (first strip reads as
//   NUM_STRIPS+1) and drops rsp_valid.
// stalls:
//   a finished word sits in the output register; the next strip is accepted
//   meanwhile, and the sequencer waits at its end until that register frees.
module strip_cluster_accumulator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  scc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output scc_pkg::rsp_type rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_MUL_SIG   = 8'b0000_0010,
      ST_MUL_NOISE = 8'b0000_0100,
      ST_MUL_MEAN  = 8'b0000_1000,
      ST_MUL_POS   = 8'b0001_0000,
      ST_DIV_START = 8'b0010_0000,
      ST_DIV_WAIT  = 8'b0100_0000,
      ST_FINISH    = 8'b1000_0000
   } seq_state_type;

   seq_state_type                    state_ff;
   logic                             rsp_valid_ff;
   scc_pkg::rsp_type                 rsp_data_ff;

   logic [scc_pkg::SUM_W-1:0]        signal_sum_ff;
   logic [scc_pkg::NOISE_W-1:0]      noise_sum_ff;
   logic [scc_pkg::LOW_W-1:0]        low_strip_ff;
   logic [scc_pkg::SIGNAL_W-1:0]     low_signal_ff;
   logic [scc_pkg::SIGNAL_W-1:0]     edge_signal_ff;
   logic [scc_pkg::COUNT_W-1:0]      count_ff;
   logic [scc_pkg::MEAN_W-1:0]       mean_ff;
   logic                             zero_ff;

   scc_pkg::req_type                 in_ff;
   logic [scc_pkg::WEIGHT_W-1:0]     weight_ff;
   logic [scc_pkg::SIGNAL_W-1:0]     wsig_ff;
   logic [scc_pkg::SUM_W-1:0]        new_sum_ff;
   logic [scc_pkg::ACC_W-1:0]        acc_ff;

   logic [scc_pkg::MUL_A_W-1:0]      mul_a;
   logic [scc_pkg::MUL_B_W-1:0]      mul_b;
   logic [scc_pkg::MUL_P_W-1:0]      mul_prod;

   logic [scc_pkg::SUM_W:0]          sig_sum_wide;
   logic [scc_pkg::NOISE_W:0]        noise_sum_wide;
   logic [scc_pkg::LOW_W-1:0]        strip_ext;
   logic                             low_take;
   logic [scc_pkg::LOW_W-1:0]        low_new;
   logic [scc_pkg::LOW_W:0]          edge_limit;
   logic                             edge_take;

   logic                             req_fire;
   logic                             rsp_load;
   scc_pkg::div_req_type             div_req;
   logic                             div_done;
   logic [scc_pkg::MEAN_W-1:0]       div_quot;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_MUL_SIG: begin
            mul_a = scc_pkg::MUL_A_W'(in_ff.strip_signal);
            mul_b = scc_pkg::MUL_B_W'(weight_ff);
         end
         ST_MUL_NOISE: begin
            mul_a = scc_pkg::MUL_A_W'(in_ff.strip_sigma);
            mul_b = scc_pkg::MUL_B_W'(weight_ff);
         end
         ST_MUL_MEAN: begin
            mul_a = signal_sum_ff;
            mul_b = mean_ff;
         end
         ST_MUL_POS: begin
            mul_a = scc_pkg::MUL_A_W'(in_ff.strip_number);
            mul_b = scc_pkg::MUL_B_W'(wsig_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_prod = scc_pkg::MUL_P_W'(mul_a) * scc_pkg::MUL_P_W'(mul_b);
   end

   always_comb begin
      sig_sum_wide   = {1'b0, signal_sum_ff} + (scc_pkg::SUM_W + 1)'(wsig_ff);
      noise_sum_wide = {1'b0, noise_sum_ff}
                       + (scc_pkg::NOISE_W + 1)'(mul_prod[30:15]);
      strip_ext      = scc_pkg::LOW_W'(in_ff.strip_number);
      low_take       = strip_ext < low_strip_ff;
      low_new        = low_take ? strip_ext : low_strip_ff;
      edge_limit     = {1'b0, low_new} + (scc_pkg::LOW_W + 1)'(count_ff);
      edge_take      = {1'b0, strip_ext} >= edge_limit;
   end

   always_comb begin
      div_req.start    = (state_ff == ST_DIV_START) && (signal_sum_ff != '0);
      div_req.dividend = acc_ff;
      div_req.divisor  = signal_sum_ff;
   end

   scc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   // sequencer and cluster state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         signal_sum_ff  <= '0;
         noise_sum_ff   <= '0;
         low_strip_ff   <= scc_pkg::LOW_EMPTY;
         low_signal_ff  <= '0;
         edge_signal_ff <= '0;
         count_ff       <= '0;
         mean_ff        <= '0;
         zero_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_MUL_SIG;
                  if (req_data.start_cluster) begin
                     signal_sum_ff  <= '0;
                     noise_sum_ff   <= '0;
                     low_strip_ff   <= scc_pkg::LOW_EMPTY;
                     low_signal_ff  <= '0;
                     edge_signal_ff <= '0;
                     count_ff       <= '0;
                     mean_ff        <= '0;
                  end
               end
            end
            ST_MUL_SIG: begin
               state_ff <= ST_MUL_NOISE;
            end
            ST_MUL_NOISE: begin
               noise_sum_ff <= noise_sum_wide[scc_pkg::NOISE_W]
                               ? scc_pkg::NOISE_MAX
                               : noise_sum_wide[scc_pkg::NOISE_W-1:0];
               state_ff     <= ST_MUL_MEAN;
            end
            ST_MUL_MEAN: begin
               state_ff <= ST_MUL_POS;
            end
            ST_MUL_POS: begin
               signal_sum_ff <= new_sum_ff;
               if (low_take) begin
                  low_strip_ff  <= strip_ext;
                  low_signal_ff <= wsig_ff;
               end
               if (edge_take) begin
                  edge_signal_ff <= wsig_ff;
               end
               if (count_ff < scc_pkg::COUNT_MAX) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= ST_DIV_START;
            end
            ST_DIV_START: begin
               if (signal_sum_ff == '0) begin
                  zero_ff  <= 1'b1;
                  state_ff <= ST_FINISH;
               end else begin
                  zero_ff  <= 1'b0;
                  state_ff <= ST_DIV_WAIT;
               end
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  mean_ff  <= div_quot;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // working registers and output word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff     <= req_data;
         weight_ff <= (req_data.share_weight > scc_pkg::ONE_Q15)
                      ? scc_pkg::ONE_Q15 : req_data.share_weight;
      end
      case (state_ff)
         ST_MUL_SIG: begin
            wsig_ff <= mul_prod[24:15];
         end
         ST_MUL_NOISE: begin
            new_sum_ff <= sig_sum_wide[scc_pkg::SUM_W]
                          ? scc_pkg::SIG_MAX : sig_sum_wide[scc_pkg::SUM_W-1:0];
         end
         ST_MUL_MEAN: begin
            acc_ff <= {1'b0, mul_prod};
         end
         ST_MUL_POS: begin
            acc_ff <= acc_ff + {1'b0, mul_prod[29:0], 8'b0};
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_data_ff.total_signal <= signal_sum_ff;
         rsp_data_ff.total_noise  <= noise_sum_ff;
         rsp_data_ff.first_strip  <= low_strip_ff[scc_pkg::STRIP_W-1:0];
         rsp_data_ff.first_signal <= low_signal_ff;
         rsp_data_ff.last_signal  <= edge_signal_ff;
         rsp_data_ff.strip_count  <= count_ff;
         rsp_data_ff.centroid     <= mean_ff;
         rsp_data_ff.zero_total   <= zero_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
